// ----- design/scpid_pkg.sv -----
// ---------------------------------------------------------------------------
// scpid_pkg: shared types and constants
// Register indexes, sequencer states and controller constants.
// ---------------------------------------------------------------------------
package scpid_pkg;

	localparam int HOLD_TICKS        = 1000;
	localparam int UPDATE_TICKS      = 5000;
	localparam int OPEN_LOOP_CURRENT = 2048;
	localparam int DERIV_FILTER_GAIN = 16;
	localparam int ERR_CLAMP         = 1638;
	localparam int LEAD_BASE         = 82;
	localparam int ADV_MAX           = 68;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRIVE_MODE  = 3'd0,
		REG_PROP_GAIN   = 3'd1,
		REG_INTEG_GAIN  = 3'd2,
		REG_DERIV_GAIN  = 3'd3,
		REG_DERIV_KEEP  = 3'd4,
		REG_INTEG_LIMIT = 3'd5,
		REG_CUR_LIMIT   = 3'd6,
		REG_STEP_SCALE  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_OPEN   = 2'd1,
		MODE_CLOSED = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	// Sequencer: ST_TGT, ST_INTEG, ST_KEEP, ST_DGAIN and ST_PROP each drive the shared multiplier once.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TGT,     // step_scale * pulse_count
		ST_POS,     // target/meas, error, delta
		ST_INTEG,   // integ_gain * err
		ST_KEEP,    // keep * filtered_deriv
		ST_DGAIN,   // deriv_gain * delta
		ST_DERIV,   // combine derivative
		ST_PROP,    // prop_gain * err
		ST_DRIVE,   // phase/current
		ST_OUT
	} state_t;

endpackage

// ----- design/scpid_if.sv -----
// ---------------------------------------------------------------------------
// scpid_in_if / scpid_out_if: valid/ready channels
// Input tick channel and result channel.
// ---------------------------------------------------------------------------
interface scpid_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pulse_count;
	logic [13:0] measured_angle;
	modport source (output valid, pulse_count, measured_angle, input ready);
	modport sink   (input valid, pulse_count, measured_angle, output ready);
endinterface

interface scpid_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] phase_angle;
	logic [11:0]        drive_current;
	logic               limit_hit;
	logic               update_pulse;
	modport source (output valid, phase_angle, drive_current, limit_hit, update_pulse,
		input ready);
	modport sink   (input valid, phase_angle, drive_current, limit_hit, update_pulse,
		output ready);
endinterface

// ----- design/stepper_closed_loop_pid_step_top.sv -----
// ---------------------------------------------------------------------------
// stepper_closed_loop_pid_step_top: closed/open loop stepper tick controller
// Unwraps step count and rotor angle, runs PID or open-loop drive.
// ---------------------------------------------------------------------------
// One tick is processed at a time through a single shared 33x33 signed
// multiplier stepped by a small sequencer: closed-loop ticks step TGT, POS,
// INTEG, KEEP, DGAIN, DERIV, PROP, DRIVE, OUT; open-loop ticks TGT, POS, OUT;
// disabled ticks, no result. The input is not ready again until the result
// register is taken. Users must write configuration only when idle; unenforced.
module stepper_closed_loop_pid_step_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scpid_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [scpid_pkg::CFG_DATA_W-1:0] cfg_data,
	scpid_in_if.sink                       in_ch,
	scpid_out_if.source                    out_ch
);
	import scpid_pkg::*;

	// Configuration registers
	logic [1:0]  mode_q;
	logic [15:0] kp_q, ki_q, kd_q;
	logic [7:0]  keep_q;
	logic [23:0] ilim_q;
	logic [11:0] clim_q;
	logic [10:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; kp_q <= '0; ki_q <= '0; kd_q <= '0;
			keep_q <= '0; ilim_q <= '0; clim_q <= '0; scale_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_DRIVE_MODE:  mode_q  <= cfg_data[1:0];
				REG_PROP_GAIN:   kp_q    <= cfg_data[15:0];
				REG_INTEG_GAIN:  ki_q    <= cfg_data[15:0];
				REG_DERIV_GAIN:  kd_q    <= cfg_data[15:0];
				REG_DERIV_KEEP:  keep_q  <= cfg_data[7:0];
				REG_INTEG_LIMIT: ilim_q  <= cfg_data;
				REG_CUR_LIMIT:   clim_q  <= cfg_data[11:0];
				REG_STEP_SCALE:  scale_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Controller state
	logic [15:0]        last_pc_q;
	logic [31:0]        wrap_sum_q;
	logic [13:0]        last_ang_q;
	logic [17:0]        turns_q;
	logic [31:0]        last_pos_q, last_tgt_q;
	logic signed [31:0] integ_q, fderiv_q;
	logic [9:0]         rest_q;
	logic [12:0]        upd_cnt_q;

	// Working registers
	state_t             st_q, st_d;
	logic [15:0]        pc_q;
	logic [13:0]        ang_q;
	logic [31:0]        tgt_q;
	logic signed [11:0] err_q;
	logic signed [31:0] delta_q;
	logic signed [65:0] prod_q;
	logic signed [39:0] keep_t_q;
	logic signed [63:0] acc_q;

	// Shared multiplier operands
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_TGT:   begin mul_a = 33'(scale_q);  mul_b = 33'(pc_q); end
			ST_INTEG: begin mul_a = 33'(ki_q);     mul_b = 33'(err_q); end
			ST_KEEP:  begin mul_a = 33'(keep_q);   mul_b = 33'(fderiv_q); end
			ST_DGAIN: begin mul_a = 33'(kd_q);     mul_b = 33'(delta_q); end
			ST_PROP:  begin mul_a = 33'(kp_q);     mul_b = 33'(err_q); end
			default:  ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Unwrap step counter
	logic signed [16:0] dpc;
	logic [31:0]        wrap_next;
	assign dpc = $signed({1'b0, pc_q}) - $signed({1'b0, last_pc_q});
	always_comb begin
		wrap_next = wrap_sum_q;
		if (dpc < -17'sd32768)     wrap_next = wrap_sum_q + {5'd0, scale_q, 16'd0};
		else if (dpc > 17'sd32768) wrap_next = wrap_sum_q - {5'd0, scale_q, 16'd0};
	end

	// Angle unwrap and error/delta
	logic signed [14:0] dang;
	logic [17:0]        turns_next;
	logic [31:0]        meas_c, tgt_c;
	logic signed [31:0] perr;
	logic signed [11:0] err_c;
	assign dang = $signed({1'b0, ang_q}) - $signed({1'b0, last_ang_q});
	always_comb begin
		turns_next = turns_q;
		if (dang > 15'sd8192)       turns_next = turns_q - 18'd1;
		else if (dang < -15'sd8192) turns_next = turns_q + 18'd1;
	end
	assign tgt_c  = tgt_q;
	assign meas_c = {turns_next, 14'd0} + {18'd0, ang_q};
	assign perr   = $signed(tgt_c - meas_c);
	always_comb begin
		if (perr > 32'sd1638)       err_c = 12'sd1638;
		else if (perr < -32'sd1638) err_c = -12'sd1638;
		else                        err_c = perr[11:0];
	end

	// Integral: truncating /32, clamp
	logic signed [63:0] iq, isum, ilim_s, integ_c;
	always_comb begin
		iq = prod_q[63:0];
		iq = (iq < 0) ? -((-iq) >>> 5) : (iq >>> 5);
		isum = 64'(integ_q) + iq;
		ilim_s = $signed({40'd0, ilim_q});
		if (isum > ilim_s)       integ_c = ilim_s;
		else if (isum < -ilim_s) integ_c = -ilim_s;
		else                     integ_c = isum;
	end

	// Derivative: keep term /128, gain term *16/8 = *2
	logic signed [39:0] keep_c;
	logic signed [63:0] draw, dsat;
	always_comb begin
		keep_c = prod_q[39:0];
		keep_c = (keep_c < 0) ? -((-keep_c) >>> 7) : (keep_c >>> 7);
		draw = 64'(keep_t_q) - (prod_q[63:0] <<< 1);
		if (draw > 64'sd2147483647)       dsat = 64'sd2147483647;
		else if (draw < -64'sd2147483648) dsat = -64'sd2147483648;
		else                              dsat = draw;
	end

	// Drive: u = (kp*err + acc)/128, advance, current clamp
	logic signed [63:0] usum, u_c, uabs;
	logic signed [33:0] adv_c;
	logic signed [31:0] phase_c;
	logic [11:0]        cur_c;
	logic               hit_c;
	always_comb begin
		usum = prod_q[63:0] + acc_q;
		u_c  = (usum < 0) ? -((-usum) >>> 7) : (usum >>> 7);
		adv_c = 34'(delta_q) * 34'sd3;
		adv_c = (adv_c < 0) ? -((-adv_c) >>> 1) : (adv_c >>> 1);
		phase_c = 32'({18'd0, ang_q});
		uabs = u_c;
		if (u_c > 0) begin
			if (adv_c < 0) adv_c = '0;
			else if (adv_c > 34'sd68) adv_c = 34'sd68;
			phase_c = phase_c + 32'sd82 + adv_c[31:0];
		end else if (u_c < 0) begin
			if (adv_c > 0) adv_c = '0;
			else if (adv_c < -34'sd68) adv_c = -34'sd68;
			phase_c = phase_c - 32'sd82 + adv_c[31:0];
			uabs = -u_c;
		end
		hit_c = uabs > $signed({52'd0, clim_q});
		cur_c = hit_c ? clim_q : uabs[11:0];
	end

	// Open-loop rest counter
	logic [9:0] rest_c;
	always_comb begin
		if (tgt_c == last_tgt_q)
			rest_c = (rest_q >= 10'(HOLD_TICKS - 1)) ? 10'(HOLD_TICKS) : rest_q + 10'd1;
		else
			rest_c = '0;
	end

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (in_ch.valid &&
				(mode_q == MODE_OPEN || mode_q == MODE_CLOSED)) st_d = ST_TGT;
			ST_TGT:   st_d = ST_POS;
			ST_POS:   st_d = (mode_q == MODE_CLOSED) ? ST_INTEG : ST_OUT;
			ST_INTEG: st_d = ST_KEEP;
			ST_KEEP:  st_d = ST_DGAIN;
			ST_DGAIN: st_d = ST_DERIV;
			ST_DERIV: st_d = ST_PROP;
			ST_PROP:  st_d = ST_DRIVE;
			ST_DRIVE: st_d = ST_OUT;
			ST_OUT:   if (out_ch.ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ch.ready  = (st_q == ST_IDLE);
		out_ch.valid = (st_q == ST_OUT);
	end

	logic [12:0] upd_inc;
	assign upd_inc = upd_cnt_q + 13'd1;

	// Product registered one state after it is formed: ki*err is in prod_q
	// during ST_KEEP, keep*fderiv during ST_DGAIN.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			last_pc_q <= '0; wrap_sum_q <= '0; last_ang_q <= '0; turns_q <= '0;
			last_pos_q <= '0; last_tgt_q <= '0; integ_q <= '0; fderiv_q <= '0;
			rest_q <= '0; upd_cnt_q <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_TGT: begin
					wrap_sum_q <= wrap_next;
					last_pc_q  <= pc_q;
				end
				ST_POS: begin
					if (mode_q == MODE_CLOSED) begin
						turns_q    <= turns_next;
						last_ang_q <= ang_q;
						last_pos_q <= meas_c;
					end else begin
						rest_q     <= rest_c;
						last_tgt_q <= tgt_c;
					end
					if (upd_inc >= 13'(UPDATE_TICKS)) upd_cnt_q <= upd_inc - 13'(UPDATE_TICKS);
					else                              upd_cnt_q <= upd_inc;
				end
				ST_KEEP:  integ_q  <= integ_c[31:0];
				ST_DERIV: fderiv_q <= dsat[31:0];
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (st_q)
			ST_IDLE: begin
				pc_q  <= in_ch.pulse_count;
				ang_q <= in_ch.measured_angle;
			end
			ST_TGT: tgt_q <= wrap_next + mul_p[31:0];
			ST_POS: begin
				err_q   <= err_c;
				delta_q <= $signed(meas_c - last_pos_q);
				out_ch.update_pulse  <= upd_inc >= 13'(UPDATE_TICKS);
				out_ch.phase_angle   <= $signed(tgt_c);
				out_ch.drive_current <= (rest_c >= 10'(HOLD_TICKS)) ?
					12'(OPEN_LOOP_CURRENT / 2) : 12'(OPEN_LOOP_CURRENT);
				out_ch.limit_hit     <= 1'b0;
			end
			ST_KEEP:  acc_q <= integ_c;
			ST_DGAIN: keep_t_q <= keep_c;
			ST_DERIV: acc_q <= acc_q + dsat;
			ST_DRIVE: begin
				out_ch.phase_angle   <= phase_c;
				out_ch.drive_current <= cur_c;
				out_ch.limit_hit     <= hit_c;
			end
			default: ;
		endcase
	end

endmodule

// ----- design/scpid_check.sv -----
// ---------------------------------------------------------------------------
// scpid_check: port-level checks
// Handshake and result-field properties seen at the top-level ports.
// ---------------------------------------------------------------------------
module scpid_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_phase,
	input logic [11:0] out_cur,
	input logic        out_hit
);
	// One tick at a time: no input while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// Result held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_phase))
		else $error("result dropped");
	// A presented result carries known field values
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({out_phase, out_cur, out_hit}))
		else $error("unknown result field");
	// After a result transfer the block is ready again
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("not ready after result");
endmodule

bind stepper_closed_loop_pid_step_top scpid_check u_scpid_check (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_phase(out_ch.phase_angle), .out_cur(out_ch.drive_current),
	.out_hit(out_ch.limit_hit)
);

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: stepper PID tick controller
// Drives control ticks through the valid/ready channels under several register
// settings and random idling. A scoreboard class predicts every result from
// its own copy of the controller state and checks each result transfer.
// ---------------------------------------------------------------------------
module testbench;
	import scpid_pkg::*;

	typedef struct packed {
		logic signed [31:0] phase;
		logic [11:0]        cur;
		logic               hit;
		logic               upd;
	} drive_cmd_t;

	// Predicts controller outputs and holds the commands still to arrive
	class pid_scoreboard;
		mode_t       mode;
		bit [15:0]   prop_gain, integ_gain, deriv_gain;
		bit [7:0]    keep;
		bit [23:0]   integ_limit;
		bit [11:0]   cur_limit;
		bit [10:0]   step_scale;

		bit [15:0]   last_pc;
		bit [31:0]   wrap_sum;
		bit [13:0]   last_ang;
		bit [17:0]   turns;
		bit [31:0]   last_pos, last_tgt;
		int          integ_acc, filt_deriv;
		int          rest_cnt, upd_cnt;

		drive_cmd_t  pending[$];
		int          errors;

		function new();
			mode = MODE_OFF;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, bit [23:0] v);
			case (idx)
				REG_DRIVE_MODE:  mode = mode_t'(v[1:0]);
				REG_PROP_GAIN:   prop_gain = v[15:0];
				REG_INTEG_GAIN:  integ_gain = v[15:0];
				REG_DERIV_GAIN:  deriv_gain = v[15:0];
				REG_DERIV_KEEP:  keep = v[7:0];
				REG_INTEG_LIMIT: integ_limit = v;
				REG_CUR_LIMIT:   cur_limit = v[11:0];
				REG_STEP_SCALE:  step_scale = v[10:0];
				default: ;
			endcase
		endfunction

		function longint clampv(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Step counter -> unwrapped target position
		function bit [31:0] target_pos(bit [15:0] pc);
			int        d;
			bit [31:0] wstep;
			d = int'({16'b0, pc}) - int'({16'b0, last_pc});
			wstep = {5'b0, step_scale, 16'b0};
			if (d < -32768)
				wrap_sum = wrap_sum + wstep;
			else if (d > 32768)
				wrap_sum = wrap_sum - wstep;
			last_pc = pc;
			return wrap_sum + 32'(step_scale) * 32'(pc);
		endfunction

		// Accepted tick: advance state and, in open or closed mode, queue the expected command
		function void note_tick(bit [15:0] pc, bit [13:0] ang);
			bit [31:0]  tgt, meas;
			int         da;
			longint     err, integ, deriv, delta, u, adv, phase;
			drive_cmd_t c;
			c = '0;
			if (mode == MODE_CLOSED) begin
				tgt = target_pos(pc);
				da = int'({18'b0, ang}) - int'({18'b0, last_ang});
				if (da > 8192)
					turns = turns - 18'd1;
				else if (da < -8192)
					turns = turns + 18'd1;
				meas = {18'b0, ang} + {turns, 14'b0};
				err = clampv(longint'(int'(tgt - meas)), -ERR_CLAMP, ERR_CLAMP);
				integ = longint'(integ_acc) + (longint'(integ_gain) * err) / 32;
				integ = clampv(integ, -longint'(integ_limit), longint'(integ_limit));
				integ_acc = int'(integ);
				delta = longint'(int'(meas - last_pos));
				deriv = (longint'(keep) * longint'(filt_deriv)) / 128
					- (longint'(DERIV_FILTER_GAIN) * longint'(deriv_gain) * delta) / 8;
				deriv = clampv(deriv, -64'sd2147483648, 64'sd2147483647);
				filt_deriv = int'(deriv);
				u = (longint'(prop_gain) * err + integ + deriv) / 128;
				adv = (3 * delta) / 2;
				last_ang = ang;
				last_pos = meas;
				phase = longint'(ang);
				if (u > 0) begin
					phase = phase + LEAD_BASE + clampv(adv, 0, ADV_MAX);
				end else if (u < 0) begin
					phase = phase - (LEAD_BASE - clampv(adv, -ADV_MAX, 0));
					u = -u;
				end
				if (u > longint'(cur_limit)) begin
					u = longint'(cur_limit);
					c.hit = 1'b1;
				end
				c.cur = u[11:0];
				c.phase = phase[31:0];
			end else if (mode == MODE_OPEN) begin
				tgt = target_pos(pc);
				if (tgt == last_tgt) begin
					rest_cnt++;
					if (rest_cnt >= HOLD_TICKS)
						rest_cnt = HOLD_TICKS;
				end else begin
					rest_cnt = 0;
				end
				c.cur = (rest_cnt >= HOLD_TICKS) ? 12'(OPEN_LOOP_CURRENT / 2)
					: 12'(OPEN_LOOP_CURRENT);
				c.phase = tgt;
				last_tgt = tgt;
			end else begin
				return;
			end
			upd_cnt++;
			if (upd_cnt >= UPDATE_TICKS) begin
				upd_cnt = upd_cnt - UPDATE_TICKS;
				c.upd = 1'b1;
			end
			pending.push_back(c);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_cmd(drive_cmd_t got);
			drive_cmd_t e;
			if (pending.size() == 0) begin
				report("result with no expected command");
				return;
			end
			e = pending.pop_front();
			if (got.phase !== e.phase)
				report($sformatf("phase_angle got %0d exp %0d", got.phase, e.phase));
			if (got.cur !== e.cur)
				report($sformatf("drive_current got %0d exp %0d", got.cur, e.cur));
			if (got.hit !== e.hit)
				report($sformatf("limit_hit got %0b exp %0b", got.hit, e.hit));
			if (got.upd !== e.upd)
				report($sformatf("update_pulse got %0b exp %0b", got.upd, e.upd));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	scpid_in_if  tick_ch();
	scpid_out_if cmd_ch();

	stepper_closed_loop_pid_step_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (tick_ch.sink),
		.out_ch   (cmd_ch.source)
	);

	pid_scoreboard sb = new();
	int            src_idle;
	int            snk_idle;
	bit [15:0]     pc_walk;
	bit [13:0]     ang_walk;

	always #5 clk = ~clk;

	// Receiver: random stall on the result channel
	always @(negedge clk) begin
		cmd_ch.ready = ($urandom_range(99) >= snk_idle);
	end

	// Result transfers go to the scoreboard
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			sb.check_cmd({cmd_ch.phase_angle, cmd_ch.drive_current,
				cmd_ch.limit_hit, cmd_ch.update_pulse});
	end

	task send_tick(bit [15:0] pc, bit [13:0] ang);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			tick_ch.valid = 1'b0;
			@(negedge clk);
		end
		tick_ch.pulse_count = pc;
		tick_ch.measured_angle = ang;
		tick_ch.valid = 1'b1;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		sb.note_tick(pc, ang);
	endtask

	// Wait out all expected commands, then the sequencer latency
	task drain;
		@(negedge clk);
		tick_ch.valid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task write_reg(reg_idx_t idx, bit [23:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task set_regs(mode_t m, bit [15:0] pg, bit [15:0] ig, bit [15:0] dg, bit [7:0] kp,
		bit [23:0] il, bit [11:0] cl, bit [10:0] ss);
		drain();
		write_reg(REG_DRIVE_MODE, 24'(m));
		write_reg(REG_PROP_GAIN, 24'(pg));
		write_reg(REG_INTEG_GAIN, 24'(ig));
		write_reg(REG_DERIV_GAIN, 24'(dg));
		write_reg(REG_DERIV_KEEP, 24'(kp));
		write_reg(REG_INTEG_LIMIT, il);
		write_reg(REG_CUR_LIMIT, 24'(cl));
		write_reg(REG_STEP_SCALE, 24'(ss));
	endtask

	// Zero, top of range or random
	function bit [23:0] pick(int hi);
		case ($urandom_range(3))
			0:       return 24'd0;
			1:       return 24'(hi);
			default: return 24'($urandom_range(hi));
		endcase
	endfunction

	// Mostly small moves of both counters, now and then a jump anywhere
	task walk_tick;
		if ($urandom_range(19) == 0) begin
			pc_walk = 16'($urandom);
			ang_walk = 14'($urandom);
		end else begin
			pc_walk = pc_walk + 16'($urandom_range(600)) - 16'd300;
			ang_walk = ang_walk + 14'($urandom_range(1200)) - 14'd600;
		end
		send_tick(pc_walk, ang_walk);
	endtask

	initial begin
		mode_t m;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.pulse_count = '0;
		tick_ch.measured_angle = '0;
		cmd_ch.ready = 1'b0;
		src_idle = 23;
		snk_idle = 61;
		pc_walk = '0;
		ang_walk = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: zero drive, field extremes, both wraps in both directions
		set_regs(MODE_CLOSED, 16'd0, 16'd0, 16'd0, 8'd0, 24'd0, 12'd0, 11'd1024);
		send_tick(16'd0, 14'd0);
		send_tick(16'hFFFF, 14'h3FFF);
		send_tick(16'd0, 14'd0);
		send_tick(16'd40000, 14'd100);
		send_tick(16'd100, 14'd16000);
		set_regs(MODE_CLOSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd128, 24'hFFFFFF,
			12'd100, 11'd1);
		send_tick(16'd5, 14'd3);
		send_tick(16'd0, 14'd9000);
		send_tick(16'hFFFF, 14'd0);
		send_tick(16'h8000, 14'h3FFF);
		send_tick(16'd10, 14'd20);
		set_regs(MODE_CLOSED, 16'd200, 16'd50, 16'd3, 8'd64, 24'd5000, 12'hFFF, 11'd7);
		send_tick(16'd12, 14'd80);
		send_tick(16'd12, 14'd60);
		send_tick(16'd9, 14'd30);
		set_regs(MODE_OPEN, 16'd1, 16'd1, 16'd1, 8'd1, 24'd1, 12'd1, 11'd0);
		send_tick(16'd3, 14'd0);
		send_tick(16'd3, 14'd5);
		send_tick(16'hFFFF, 14'h3FFF);
		send_tick(16'd0, 14'd0);
		set_regs(MODE_OFF, 16'd1, 16'd1, 16'd1, 8'd1, 24'd1, 12'd1, 11'd5);
		send_tick(16'd100, 14'd100);
		send_tick(16'd0, 14'd1);
		set_regs(MODE_RSVD, 16'd1, 16'd1, 16'd1, 8'd1, 24'd1, 12'd1, 11'd5);
		send_tick(16'd200, 14'd200);

		// Random phases under three idling schedules
		for (int ph = 0; ph < 9; ph++) begin
			src_idle = (ph < 3) ? 23 : ((ph < 6) ? 61 : 0);
			snk_idle = (ph < 3) ? 61 : ((ph < 6) ? 23 : 0);
			case ($urandom_range(9))
				0:       m = MODE_OPEN;
				1:       m = MODE_OFF;
				2:       m = MODE_RSVD;
				default: m = MODE_CLOSED;
			endcase
			if (ph == 0)
				m = MODE_CLOSED;
			set_regs(m, 16'(pick(65535)), 16'(pick(65535)), 16'(pick(65535)),
				8'(pick(128)), pick(16777215), 12'(pick(4095)), 11'(pick(1024)));
			for (int i = 0; i < 80; i++)
				walk_tick();
			if (m == MODE_OFF || m == MODE_RSVD) begin
				set_regs(MODE_CLOSED, 16'(pick(65535)), 16'(pick(65535)), 16'(pick(2000)),
					8'(pick(128)), pick(16777215), 12'(pick(4095)), 11'(pick(1024)));
				for (int i = 0; i < 80; i++)
					walk_tick();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Run limit
	initial begin
		#50000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
